FILE: sv/pts_pkg.sv
`default_nettype none
// ============================================================================
// pts_pkg: shared types and constants of the priority task scheduler
// Field widths, operation codes and the controller/datapath command bus.
// ============================================================================
package pts_pkg;

    localparam int unsigned NUM_TASKS_DEF = 16;
    localparam int unsigned NUM_SEMS_DEF  = 8;
    localparam int unsigned PRIO_BITS_DEF = 8;

    localparam int unsigned MODE_W    = 3;
    localparam int unsigned TID_W     = 4;
    localparam int unsigned PRIO_IN_W = 8;
    localparam int unsigned DLY_W     = 32;
    localparam int unsigned SEM_IN_W  = 3;
    localparam int unsigned CUR_W     = 4;

    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned S_TUSER_W = MODE_W;
    localparam int unsigned M_TDATA_W = 8;

    localparam logic [MODE_W-1:0] MODE_INSTALL    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_TICK       = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SCHEDULE   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DELAY      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PEND       = 3'd4;
    localparam logic [MODE_W-1:0] MODE_POST       = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SEM_INIT   = 3'd6;
    localparam logic [MODE_W-1:0] MODE_MUTEX_INIT = 3'd7;

    // task table read port address source
    localparam logic [1:0] RD_T    = 2'd0;
    localparam logic [1:0] RD_SCAN = 2'd1;
    localparam logic [1:0] RD_HIT  = 2'd2;

    typedef struct packed {
        logic       load;
        logic [1:0] rd_sel;
        logic       t_load_hit;
        logic       tick_inc;
        logic       del_ready;
        logic       del_timed;
        logic       del_wait;
        logic       add_ready;
        logic       add_timed;
        logic       add_wait;
        logic       set_prio;
        logic       set_wake;
        logic       token_set;
        logic       token_clr;
        logic       sem_init;
        logic       scan_clr;
        logic       cnt_step;
        logic       best_step;
        logic       rank_clr;
        logic       rank_inc;
        logic       woke_set;
        logic       acq_set;
        logic       sched_done;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              tid_ok;
        logic              sem_ok;
        logic              caller_ok;
        logic              token;
        logic              wait_nonempty;
        logic              hit_found;
        logic              wake_match;
        logic              rank_end;
        logic              scan_last;
        logic              dly_zero;
        logic              out_free;
    } status_t;

endpackage
`default_nettype wire

FILE: sv/pts_datapath.sv
`default_nettype none
// ============================================================================
// pts_datapath: task table, lists, semaphores and result register
// Executes one command word per cycle from the controller.
// ============================================================================
module pts_datapath #(
    parameter int unsigned NUM_TASKS = pts_pkg::NUM_TASKS_DEF,
    parameter int unsigned NUM_SEMS  = pts_pkg::NUM_SEMS_DEF,
    parameter int unsigned PRIO_BITS = pts_pkg::PRIO_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [pts_pkg::MODE_W-1:0]      in_mode,
    input  wire logic [pts_pkg::TID_W-1:0]       in_tid,
    input  wire logic [pts_pkg::PRIO_IN_W-1:0]   in_prio,
    input  wire logic [pts_pkg::DLY_W-1:0]       in_dly,
    input  wire logic [pts_pkg::SEM_IN_W-1:0]    in_sem,
    input  wire pts_pkg::cmd_t                   cmd,
    output pts_pkg::status_t                     status,
    input  wire logic                            m_tready,
    output logic                                 m_tvalid,
    output logic [pts_pkg::M_TDATA_W-1:0]        m_tdata
);
    import pts_pkg::*;

    localparam int unsigned TW = $clog2(NUM_TASKS);
    localparam int unsigned LW = $clog2(NUM_TASKS + 1);
    localparam int unsigned SW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;

    // operation registers
    logic [MODE_W-1:0]    mode_reg;
    logic                 tid_ok_reg;
    logic                 sem_ok_reg;
    logic [SW-1:0]        sem_reg;
    logic [PRIO_BITS-1:0] prio_reg;
    logic [DLY_W-1:0]     dly_reg;
    logic [TW-1:0]        t_reg;

    // scheduler state
    logic [DLY_W-1:0]     tick_reg;
    logic [TW-1:0]        run_task_reg;
    logic                 run_valid_reg;
    logic [LW-1:0]        ready_len_reg, ready_len_next;
    logic [LW-1:0]        timed_len_reg, timed_len_next;

    logic [NUM_TASKS-1:0] in_ready_reg, in_ready_next;
    logic [NUM_TASKS-1:0] in_timed_reg, in_timed_next;
    logic [NUM_TASKS-1:0] in_wait_reg, in_wait_next;
    logic [TW-1:0]        ready_rank_reg [NUM_TASKS];
    logic [TW-1:0]        ready_rank_next [NUM_TASKS];
    logic [TW-1:0]        timed_rank_reg [NUM_TASKS];
    logic [TW-1:0]        timed_rank_next [NUM_TASKS];
    logic [TW-1:0]        wait_rank_reg [NUM_TASKS];
    logic [TW-1:0]        wait_rank_next [NUM_TASKS];
    logic [SW-1:0]        wait_sem_reg [NUM_TASKS];
    logic [SW-1:0]        wait_sem_next [NUM_TASKS];
    logic [PRIO_BITS-1:0] task_prio_reg [NUM_TASKS];
    logic [PRIO_BITS-1:0] task_prio_next [NUM_TASKS];
    logic [DLY_W-1:0]     wake_reg [NUM_TASKS];
    logic [DLY_W-1:0]     wake_next [NUM_TASKS];
    logic [NUM_SEMS-1:0]  token_reg, token_next;

    // scan and search registers
    logic [LW-1:0]        r_reg;
    logic [TW-1:0]        idx_reg;
    logic [TW-1:0]        cnt_reg;
    logic                 found_reg;
    logic [TW-1:0]        best_idx_reg;
    logic [PRIO_BITS-1:0] best_prio_reg;
    logic [TW-1:0]        best_rank_reg;

    // result register
    logic                 woke_reg;
    logic                 acq_reg;
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    // table read port
    logic [TW-1:0]        rd_addr;
    logic                 rd_in_ready, rd_in_timed, rd_in_wait;
    logic [TW-1:0]        rd_ready_rank, rd_timed_rank, rd_wait_rank;
    logic [SW-1:0]        rd_wait_sem;
    logic [PRIO_BITS-1:0] rd_prio;
    logic [DLY_W-1:0]     rd_wake;

    logic [NUM_TASKS-1:0] hit_vec;
    logic [NUM_TASKS-1:0] waiter_vec;
    logic                 hit_found;
    logic [TW-1:0]        hit_idx;
    logic                 best_take;

    always_comb
    begin
        hit_found = 1'b0;
        hit_idx   = '0;
        for (int i = 0; i < NUM_TASKS; i++)
        begin
            waiter_vec[i] = in_wait_reg[i] && (wait_sem_reg[i] == sem_reg);
            if (mode_reg == MODE_POST)
                hit_vec[i] = waiter_vec[i] && (wait_rank_reg[i] == '0);
            else
                hit_vec[i] = in_timed_reg[i] && (LW'(timed_rank_reg[i]) == r_reg);
            if (hit_vec[i] && !hit_found)
            begin
                hit_found = 1'b1;
                hit_idx   = TW'(i);
            end
        end
    end

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_SCAN: rd_addr = idx_reg;
            RD_HIT:  rd_addr = hit_idx;
            default: rd_addr = t_reg;
        endcase
    end

    assign rd_in_ready   = in_ready_reg[rd_addr];
    assign rd_in_timed   = in_timed_reg[rd_addr];
    assign rd_in_wait    = in_wait_reg[rd_addr];
    assign rd_ready_rank = ready_rank_reg[rd_addr];
    assign rd_timed_rank = timed_rank_reg[rd_addr];
    assign rd_wait_rank  = wait_rank_reg[rd_addr];
    assign rd_wait_sem   = wait_sem_reg[rd_addr];
    assign rd_prio       = task_prio_reg[rd_addr];
    assign rd_wake       = wake_reg[rd_addr];

    assign best_take = rd_in_ready && (!found_reg || (rd_prio > best_prio_reg) ||
                       ((rd_prio == best_prio_reg) && (rd_ready_rank > best_rank_reg)));

    // t_reg list edits, tokens, sem init; ranks above a removed one close the gap
    always_comb
    begin
        in_ready_next   = in_ready_reg;
        in_timed_next   = in_timed_reg;
        in_wait_next    = in_wait_reg;
        ready_rank_next = ready_rank_reg;
        timed_rank_next = timed_rank_reg;
        wait_rank_next  = wait_rank_reg;
        wait_sem_next   = wait_sem_reg;
        task_prio_next  = task_prio_reg;
        wake_next       = wake_reg;
        token_next      = token_reg;
        ready_len_next  = ready_len_reg;
        timed_len_next  = timed_len_reg;

        if (cmd.del_ready && rd_in_ready)
        begin
            for (int i = 0; i < NUM_TASKS; i++)
                if (in_ready_reg[i] && (ready_rank_reg[i] > rd_ready_rank))
                    ready_rank_next[i] = ready_rank_reg[i] - TW'(1);
            in_ready_next[t_reg]   = 1'b0;
            ready_rank_next[t_reg] = '0;
            ready_len_next         = ready_len_reg - LW'(1);
        end
        if (cmd.add_ready && !rd_in_ready)
        begin
            in_ready_next[t_reg]   = 1'b1;
            ready_rank_next[t_reg] = TW'(ready_len_reg);
            ready_len_next         = ready_len_reg + LW'(1);
        end

        if (cmd.del_timed && rd_in_timed)
        begin
            for (int i = 0; i < NUM_TASKS; i++)
                if (in_timed_reg[i] && (timed_rank_reg[i] > rd_timed_rank))
                    timed_rank_next[i] = timed_rank_reg[i] - TW'(1);
            in_timed_next[t_reg]   = 1'b0;
            timed_rank_next[t_reg] = '0;
            timed_len_next         = timed_len_reg - LW'(1);
        end
        if (cmd.add_timed && !rd_in_timed)
        begin
            in_timed_next[t_reg]   = 1'b1;
            timed_rank_next[t_reg] = TW'(timed_len_reg);
            timed_len_next         = timed_len_reg + LW'(1);
        end

        if (cmd.del_wait && rd_in_wait)
        begin
            for (int i = 0; i < NUM_TASKS; i++)
                if (in_wait_reg[i] && (wait_sem_reg[i] == rd_wait_sem) &&
                    (wait_rank_reg[i] > rd_wait_rank))
                    wait_rank_next[i] = wait_rank_reg[i] - TW'(1);
            in_wait_next[t_reg]   = 1'b0;
            wait_sem_next[t_reg]  = '0;
            wait_rank_next[t_reg] = '0;
        end
        if (cmd.add_wait && !rd_in_wait)
        begin
            in_wait_next[t_reg]   = 1'b1;
            wait_sem_next[t_reg]  = sem_reg;
            wait_rank_next[t_reg] = cnt_reg;
        end

        if (cmd.sem_init)
        begin
            token_next[sem_reg] = (mode_reg == MODE_MUTEX_INIT);
            for (int i = 0; i < NUM_TASKS; i++)
                if (waiter_vec[i])
                begin
                    in_wait_next[i]   = 1'b0;
                    wait_sem_next[i]  = '0;
                    wait_rank_next[i] = '0;
                end
        end
        if (cmd.token_set)
            token_next[sem_reg] = 1'b1;
        if (cmd.token_clr)
            token_next[sem_reg] = 1'b0;
        if (cmd.set_prio)
            task_prio_next[t_reg] = prio_reg;
        if (cmd.set_wake)
            wake_next[t_reg] = dly_reg + tick_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_INSTALL;
            tid_ok_reg     <= 1'b0;
            sem_ok_reg     <= 1'b0;
            sem_reg        <= '0;
            prio_reg       <= '0;
            dly_reg        <= '0;
            t_reg          <= '0;
            tick_reg       <= '0;
            run_task_reg   <= '0;
            run_valid_reg  <= 1'b0;
            ready_len_reg  <= '0;
            timed_len_reg  <= '0;
            in_ready_reg   <= '0;
            in_timed_reg   <= '0;
            in_wait_reg    <= '0;
            ready_rank_reg <= '{default: '0};
            timed_rank_reg <= '{default: '0};
            wait_rank_reg  <= '{default: '0};
            wait_sem_reg   <= '{default: '0};
            task_prio_reg  <= '{default: '0};
            wake_reg       <= '{default: '0};
            token_reg      <= '0;
            r_reg          <= '0;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            found_reg      <= 1'b0;
            best_idx_reg   <= '0;
            best_prio_reg  <= '0;
            best_rank_reg  <= '0;
            woke_reg       <= 1'b0;
            acq_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            ready_len_reg  <= ready_len_next;
            timed_len_reg  <= timed_len_next;
            in_ready_reg   <= in_ready_next;
            in_timed_reg   <= in_timed_next;
            in_wait_reg    <= in_wait_next;
            ready_rank_reg <= ready_rank_next;
            timed_rank_reg <= timed_rank_next;
            wait_rank_reg  <= wait_rank_next;
            wait_sem_reg   <= wait_sem_next;
            task_prio_reg  <= task_prio_next;
            wake_reg       <= wake_next;
            token_reg      <= token_next;

            if (cmd.load)
            begin
                mode_reg   <= in_mode;
                tid_ok_reg <= (32'(in_tid) < NUM_TASKS);
                sem_ok_reg <= (32'(in_sem) < NUM_SEMS);
                sem_reg    <= SW'(in_sem);
                prio_reg   <= PRIO_BITS'(in_prio);
                dly_reg    <= in_dly;
                t_reg      <= (in_mode == MODE_INSTALL) ? TW'(in_tid) : run_task_reg;
                woke_reg   <= 1'b0;
                acq_reg    <= 1'b0;
            end
            else if (cmd.t_load_hit)
                t_reg <= hit_idx;

            if (cmd.tick_inc)
                tick_reg <= tick_reg + DLY_W'(1);
            if (cmd.rank_clr)
                r_reg <= '0;
            else if (cmd.rank_inc)
                r_reg <= r_reg + LW'(1);
            if (cmd.woke_set)
                woke_reg <= 1'b1;
            if (cmd.acq_set)
                acq_reg <= 1'b1;

            if (cmd.scan_clr)
            begin
                idx_reg   <= '0;
                cnt_reg   <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.cnt_step || cmd.best_step)
            begin
                idx_reg <= idx_reg + TW'(1);
                if (cmd.cnt_step && rd_in_wait && (rd_wait_sem == sem_reg))
                    cnt_reg <= cnt_reg + TW'(1);
                if (cmd.best_step && best_take)
                begin
                    found_reg     <= 1'b1;
                    best_idx_reg  <= idx_reg;
                    best_prio_reg <= rd_prio;
                    best_rank_reg <= rd_ready_rank;
                end
            end

            if (cmd.sched_done)
            begin
                run_valid_reg <= found_reg;
                run_task_reg  <= found_reg ? best_idx_reg : '0;
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= {1'b0, acq_reg, woke_reg, run_valid_reg,
                                  CUR_W'(run_task_reg)};
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        status.mode          = mode_reg;
        status.tid_ok        = tid_ok_reg;
        status.sem_ok        = sem_ok_reg;
        status.caller_ok     = run_valid_reg && rd_in_ready;
        status.token         = token_reg[sem_reg];
        status.wait_nonempty = |waiter_vec;
        status.hit_found     = hit_found;
        status.wake_match    = (rd_wake == tick_reg);
        status.rank_end      = (r_reg >= timed_len_reg);
        status.scan_last     = (idx_reg == TW'(NUM_TASKS - 1));
        status.dly_zero      = (dly_reg == '0);
        status.out_free      = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_ready_len: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(in_ready_reg) == int'(ready_len_reg))
        else $error("ready length out of step with ready set");
    a_timed_len: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(in_timed_reg) == int'(timed_len_reg))
        else $error("timed length out of step with timed set");
    a_ready_timed: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ready_reg & in_timed_reg) == '0)
        else $error("task both ready and timed");
    a_ready_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ready_reg & in_wait_reg) == '0)
        else $error("task both ready and waiting");

endmodule
`default_nettype wire

FILE: sv/pts_ctrl.sv
`default_nettype none
// ============================================================================
// pts_ctrl: operation sequencer of the priority task scheduler
// Steps each request through list edits, scans and result hand-off.
// ============================================================================
module pts_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire pts_pkg::status_t status,
    output pts_pkg::cmd_t         cmd
);
    import pts_pkg::*;

    localparam logic [4:0] S_IDLE       = 5'd0;
    localparam logic [4:0] S_DISPATCH   = 5'd1;
    localparam logic [4:0] S_INS_A      = 5'd2;
    localparam logic [4:0] S_INS_B      = 5'd3;
    localparam logic [4:0] S_TICK_LOOK  = 5'd4;
    localparam logic [4:0] S_TICK_MOVE  = 5'd5;
    localparam logic [4:0] S_DLY_A      = 5'd6;
    localparam logic [4:0] S_DLY_B      = 5'd7;
    localparam logic [4:0] S_PEND_A     = 5'd8;
    localparam logic [4:0] S_PEND_CNT   = 5'd9;
    localparam logic [4:0] S_PEND_B     = 5'd10;
    localparam logic [4:0] S_PEND_C     = 5'd11;
    localparam logic [4:0] S_POST_MOVE  = 5'd12;
    localparam logic [4:0] S_SCHED_INIT = 5'd13;
    localparam logic [4:0] S_SCHED_STEP = 5'd14;
    localparam logic [4:0] S_SCHED_DONE = 5'd15;
    localparam logic [4:0] S_FIN        = 5'd16;

    logic [4:0] state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = RD_T;
        s_tready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cmd.rd_sel = (status.mode == MODE_POST) ? RD_HIT : RD_T;
                state_next = S_FIN;
                unique case (status.mode)
                    MODE_INSTALL:
                        if (status.tid_ok)
                            state_next = S_INS_A;
                    MODE_TICK:
                    begin
                        cmd.tick_inc = 1'b1;
                        cmd.rank_clr = 1'b1;
                        state_next   = S_TICK_LOOK;
                    end
                    MODE_SCHEDULE:
                        state_next = S_SCHED_INIT;
                    MODE_DELAY:
                        if (status.caller_ok)
                            state_next = S_DLY_A;
                    MODE_PEND:
                        if (status.sem_ok && status.caller_ok)
                        begin
                            if (status.token)
                            begin
                                cmd.token_clr = 1'b1;
                                cmd.acq_set   = 1'b1;
                            end
                            else
                                state_next = S_PEND_A;
                        end
                    MODE_POST:
                        if (status.sem_ok)
                        begin
                            if (!status.wait_nonempty)
                                cmd.token_set = 1'b1;
                            else if (status.hit_found)
                            begin
                                cmd.t_load_hit = 1'b1;
                                state_next     = S_POST_MOVE;
                            end
                            else
                                state_next = S_SCHED_INIT;
                        end
                    default:
                        if (status.sem_ok)
                            cmd.sem_init = 1'b1;
                endcase
            end
            S_INS_A:
            begin
                cmd.del_wait  = 1'b1;
                cmd.del_timed = 1'b1;
                cmd.del_ready = 1'b1;
                state_next    = S_INS_B;
            end
            S_INS_B:
            begin
                cmd.set_prio  = 1'b1;
                cmd.add_ready = 1'b1;
                state_next    = S_FIN;
            end
            S_TICK_LOOK:
            begin
                // walk timed order by rank; a woken task closes the gap
                cmd.rd_sel = RD_HIT;
                if (status.rank_end)
                    state_next = S_FIN;
                else if (status.hit_found && status.wake_match)
                begin
                    cmd.t_load_hit = 1'b1;
                    state_next     = S_TICK_MOVE;
                end
                else
                    cmd.rank_inc = 1'b1;
            end
            S_TICK_MOVE:
            begin
                cmd.del_timed = 1'b1;
                cmd.del_wait  = 1'b1;
                cmd.add_ready = 1'b1;
                cmd.woke_set  = 1'b1;
                state_next    = S_TICK_LOOK;
            end
            S_DLY_A:
            begin
                cmd.set_wake  = 1'b1;
                cmd.del_ready = 1'b1;
                cmd.del_timed = 1'b1;
                state_next    = S_DLY_B;
            end
            S_DLY_B:
            begin
                cmd.add_timed = 1'b1;
                state_next    = S_SCHED_INIT;
            end
            S_PEND_A:
            begin
                cmd.del_ready = 1'b1;
                cmd.del_wait  = 1'b1;
                cmd.scan_clr  = 1'b1;
                state_next    = S_PEND_CNT;
            end
            S_PEND_CNT:
            begin
                // count current waiters to get the tail rank
                cmd.rd_sel   = RD_SCAN;
                cmd.cnt_step = 1'b1;
                if (status.scan_last)
                    state_next = S_PEND_B;
            end
            S_PEND_B:
            begin
                cmd.add_wait = 1'b1;
                if (!status.dly_zero)
                begin
                    cmd.set_wake  = 1'b1;
                    cmd.del_timed = 1'b1;
                    state_next    = S_PEND_C;
                end
                else
                    state_next = S_SCHED_INIT;
            end
            S_PEND_C:
            begin
                cmd.add_timed = 1'b1;
                state_next    = S_SCHED_INIT;
            end
            S_POST_MOVE:
            begin
                cmd.del_wait  = 1'b1;
                cmd.del_timed = 1'b1;
                cmd.add_ready = 1'b1;
                state_next    = S_SCHED_INIT;
            end
            S_SCHED_INIT:
            begin
                cmd.scan_clr = 1'b1;
                state_next   = S_SCHED_STEP;
            end
            S_SCHED_STEP:
            begin
                cmd.rd_sel    = RD_SCAN;
                cmd.best_step = 1'b1;
                if (status.scan_last)
                    state_next = S_SCHED_DONE;
            end
            S_SCHED_DONE:
            begin
                cmd.sched_done = 1'b1;
                state_next     = S_FIN;
            end
            S_FIN:
            begin
                // hold until the result register is free
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_DISPATCH)
        else $error("request load did not advance to dispatch");
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && !status.out_free) |=> state_reg == S_FIN)
        else $error("left finish with result register busy");
    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCHED_STEP && status.scan_last) |=> state_reg == S_SCHED_DONE)
        else $error("schedule scan did not close");

endmodule
`default_nettype wire

FILE: sv/priority_task_scheduler_semaphores.sv
`default_nettype none
// ============================================================================
// priority_task_scheduler_semaphores: task scheduler with binary semaphores
// Priority ready order, timed wakeups and FIFO semaphore waits.
// ============================================================================
//
//  channel  | direction | tdata fields (low bit first)                  | tuser
//  ---------+-----------+-----------------------------------------------+------
//  s_*      | request   | task_id, priority_req, delay_ticks, sem_id    | mode
//  m_*      | result    | active_task, task_valid, woke_any, acquired   | -
//
//  One request at a time. Init and ignored requests pass from accept through
//  dispatch to the final step; install removes the task from every list, then
//  sets its priority and re-adds it as ready; a tick walks the timed list by
//  rank, with a move step per woken task; schedule, delay, blocking pend and
//  posts that wake a waiter add a scan over every entry of the task table (a
//  blocking pend also counts the waiters in a pass over the table).
//  Reset clears all lists, tokens and the tick count at once.
//  A new request is taken while the last result waits in m_*; a stalled
//  result only holds the sequencer at its final step.
//
module priority_task_scheduler_semaphores #(
    parameter int unsigned NUM_TASKS = pts_pkg::NUM_TASKS_DEF,
    parameter int unsigned NUM_SEMS  = pts_pkg::NUM_SEMS_DEF,
    parameter int unsigned PRIO_BITS = pts_pkg::PRIO_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // task_id[3:0], priority_req[11:4], delay_ticks[43:12], sem_id[46:44]
    input  wire logic [pts_pkg::S_TDATA_W-1:0]   s_tdata,
    // mode[2:0]
    input  wire logic [pts_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // active_task[3:0], task_valid[4], woke_any[5], acquired[6]
    output logic [pts_pkg::M_TDATA_W-1:0]        m_tdata
);
    import pts_pkg::*;

    localparam int unsigned PRIO_LSB = TID_W;
    localparam int unsigned DLY_LSB  = PRIO_LSB + PRIO_IN_W;
    localparam int unsigned SEM_LSB  = DLY_LSB + DLY_W;

    cmd_t    cmd;
    status_t status;

    // sequencer: one state per list edit or scan step
    pts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // task table, lists, tokens and the result register
    pts_datapath #(
        .NUM_TASKS (NUM_TASKS),
        .NUM_SEMS  (NUM_SEMS),
        .PRIO_BITS (PRIO_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_mode  (s_tuser[MODE_W-1:0]),
        .in_tid   (s_tdata[TID_W-1:0]),
        .in_prio  (s_tdata[DLY_LSB-1:PRIO_LSB]),
        .in_dly   (s_tdata[SEM_LSB-1:DLY_LSB]),
        .in_sem   (s_tdata[SEM_LSB+SEM_IN_W-1:SEM_LSB]),
        .cmd      (cmd),
        .status   (status),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top: testbench of the priority task scheduler with binary semaphores
// Drives requests from a directed table and then from random kernel call
// sequences, predicts every result with a behavioral copy of the scheduler
// and compares each result field by field against the oldest prediction.
// ============================================================================
module tb_top;

    import pts_pkg::*;

    localparam int NT        = 16;
    localparam int NS        = 8;
    localparam int LIMIT     = 400000;
    localparam int N_RANDOM  = 1030;

    typedef struct packed {
        logic [3:0] cur;
        logic       vld;
        logic       woke;
        logic       acq;
    } sched_result_t;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [3:0]        tid;
        logic [7:0]        prio;
        logic [31:0]       dly;
        logic [2:0]        sem;
    } sched_req_t;

    typedef struct {
        sched_req_t req;
        logic       fixed;   // expected result typed in by hand
        sched_result_t res;
    } directed_row_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    priority_task_scheduler_semaphores dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // task_id, priority_req, delay_ticks, sem_id
        .s_tuser  (s_tuser),   // mode
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // active_task, task_valid, woke_any, acquired
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Scheduler shadow state
    // ------------------------------------------------------------------------
    logic [31:0] now_ticks;
    logic [3:0]  run_task;
    logic        run_valid;
    logic [7:0]  prio_of [NT];
    logic        rdy     [NT];
    int          rdy_pos [NT];
    logic        tmd     [NT];
    int          tmd_pos [NT];
    logic [31:0] wake_at [NT];
    logic        waiting [NT];
    int          wait_on [NT];
    int          wait_pos[NT];
    logic        token   [NS];
    int          rdy_len;
    int          tmd_len;
    int          wait_len[NS];

    sched_result_t expected_results[$];
    int  errors;
    int  cycles;
    logic hold_off;

    task automatic clear_shadow();
        now_ticks = '0;
        run_task  = '0;
        run_valid = 1'b0;
        rdy_len   = 0;
        tmd_len   = 0;
        for (int i = 0; i < NT; i++)
        begin
            prio_of[i] = '0; rdy[i] = 0; rdy_pos[i] = 0; tmd[i] = 0; tmd_pos[i] = 0;
            wake_at[i] = '0; waiting[i] = 0; wait_on[i] = 0; wait_pos[i] = 0;
        end
        for (int s = 0; s < NS; s++)
        begin
            token[s] = 0;
            wait_len[s] = 0;
        end
    endtask

    function automatic void ready_push(int t);
        if (rdy[t]) return;
        rdy[t] = 1; rdy_pos[t] = rdy_len; rdy_len++;
    endfunction

    function automatic void ready_drop(int t);
        if (!rdy[t]) return;
        for (int i = 0; i < NT; i++)
            if (rdy[i] && rdy_pos[i] > rdy_pos[t]) rdy_pos[i]--;
        rdy[t] = 0; rdy_pos[t] = 0; rdy_len--;
    endfunction

    function automatic void timed_push(int t);
        if (tmd[t]) return;
        tmd[t] = 1; tmd_pos[t] = tmd_len; tmd_len++;
    endfunction

    function automatic void timed_drop(int t);
        if (!tmd[t]) return;
        for (int i = 0; i < NT; i++)
            if (tmd[i] && tmd_pos[i] > tmd_pos[t]) tmd_pos[i]--;
        tmd[t] = 0; tmd_pos[t] = 0; tmd_len--;
    endfunction

    function automatic void wait_push(int t, int s);
        if (waiting[t]) return;
        waiting[t] = 1; wait_on[t] = s; wait_pos[t] = wait_len[s]; wait_len[s]++;
    endfunction

    function automatic void wait_drop(int t);
        int s;
        if (!waiting[t]) return;
        s = wait_on[t];
        for (int i = 0; i < NT; i++)
            if (waiting[i] && wait_on[i] == s && wait_pos[i] > wait_pos[t]) wait_pos[i]--;
        waiting[t] = 0; wait_on[t] = 0; wait_pos[t] = 0; wait_len[s]--;
    endfunction

    // Pick the most urgent ready task; on a tie the latest in ready order wins.
    function automatic void pick_running();
        int  best;
        logic found;
        best = 0;
        found = 0;
        for (int i = 0; i < NT; i++)
        begin
            if (!rdy[i]) continue;
            if (!found || prio_of[i] > prio_of[best] ||
                (prio_of[i] == prio_of[best] && rdy_pos[i] > rdy_pos[best]))
            begin
                best = i;
                found = 1;
            end
        end
        run_valid = found;
        run_task  = found ? 4'(best) : 4'd0;
    endfunction

    function automatic logic caller_running();
        return run_valid && rdy[run_task];
    endfunction

    // Apply one request to the shadow state and return the scheduler's answer.
    function automatic sched_result_t predict_kernel_call(sched_req_t r);
        sched_result_t res;
        int woken[$];
        int t;
        int s;
        res = '0;
        s = r.sem;
        case (r.mode)
            MODE_INSTALL:
            begin
                t = r.tid;
                wait_drop(t);
                timed_drop(t);
                ready_drop(t);
                prio_of[t] = r.prio;
                ready_push(t);
            end
            MODE_TICK:
            begin
                now_ticks++;
                for (int k = 0; k < tmd_len; k++)
                    for (int i = 0; i < NT; i++)
                        if (tmd[i] && tmd_pos[i] == k && wake_at[i] == now_ticks)
                            woken.push_back(i);
                foreach (woken[k])
                begin
                    timed_drop(woken[k]);
                    wait_drop(woken[k]);
                    ready_push(woken[k]);
                end
                res.woke = woken.size() != 0;
            end
            MODE_SCHEDULE:
                pick_running();
            MODE_DELAY:
                if (caller_running())
                begin
                    t = run_task;
                    wake_at[t] = r.dly + now_ticks;
                    ready_drop(t);
                    timed_drop(t);
                    timed_push(t);
                    pick_running();
                end
            MODE_PEND:
                if (caller_running())
                begin
                    t = run_task;
                    if (token[s])
                    begin
                        token[s] = 0;
                        res.acq = 1;
                    end
                    else
                    begin
                        ready_drop(t);
                        wait_drop(t);
                        wait_push(t, s);
                        if (r.dly != 0)
                        begin
                            wake_at[t] = r.dly + now_ticks;
                            timed_drop(t);
                            timed_push(t);
                        end
                        pick_running();
                    end
                end
            MODE_POST:
                if (wait_len[s] == 0)
                    token[s] = 1;
                else
                begin
                    for (int i = 0; i < NT; i++)
                        if (waiting[i] && wait_on[i] == s && wait_pos[i] == 0)
                        begin
                            wait_drop(i);
                            timed_drop(i);
                            ready_push(i);
                            break;
                        end
                    pick_running();
                end
            default:
            begin
                // init drops every waiter; timed ones keep their timeout
                token[s] = (r.mode == MODE_MUTEX_INIT);
                for (int i = 0; i < NT; i++)
                    if (waiting[i] && wait_on[i] == s)
                    begin
                        waiting[i] = 0; wait_on[i] = 0; wait_pos[i] = 0;
                    end
                wait_len[s] = 0;
            end
        endcase
        res.cur = run_valid ? run_task : 4'd0;
        res.vld = run_valid;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    function automatic sched_req_t mk(logic [2:0] m, int tid, int prio, logic [31:0] d,
                                      int sem);
        sched_req_t r;
        r.mode = m; r.tid = 4'(tid); r.prio = 8'(prio); r.dly = d; r.sem = 3'(sem);
        return r;
    endfunction

    int burst_left;

    // Offer one request and hold it until it is taken; gaps fall between bursts.
    // Valid stays up after a take only when the next request follows at once.
    task automatic send_request(sched_req_t r);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= {1'b0, r.sem, r.dly, r.prio, r.tid};
        s_tuser  <= r.mode;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        expected_results.push_back(predict_kernel_call(r));
        @(negedge clk);
    endtask

    // Drop valid, then hold until every predicted result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (expected_results.size() != 0) @(negedge clk);
    endtask

    function automatic sched_req_t random_request();
        int pick;
        logic [31:0] d;
        pick = $urandom_range(0, 99);
        // Mostly short delays/timeouts so timed tasks actually wake; a few wide ones.
        d = ($urandom_range(0, 9) == 0) ? $urandom() : 32'($urandom_range(0, 6));
        if (pick < 12)
            return mk(MODE_INSTALL, $urandom_range(0, 15),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 3), d,
                      $urandom_range(0, 7));
        else if (pick < 34)
            return mk(MODE_TICK, $urandom_range(0, 15), $urandom_range(0, 255), d,
                      $urandom_range(0, 7));
        else if (pick < 44)
            return mk(MODE_SCHEDULE, $urandom_range(0, 15), $urandom_range(0, 255), d,
                      $urandom_range(0, 7));
        else if (pick < 54)
            return mk(MODE_DELAY, $urandom_range(0, 15), $urandom_range(0, 255), d,
                      $urandom_range(0, 7));
        else if (pick < 72)
            return mk(MODE_PEND, $urandom_range(0, 15), $urandom_range(0, 255), d,
                      $urandom_range(0, 2));
        else if (pick < 92)
            return mk(MODE_POST, $urandom_range(0, 15), $urandom_range(0, 255), d,
                      $urandom_range(0, 2));
        else
            return mk(($urandom_range(0, 1) != 0) ? MODE_MUTEX_INIT : MODE_SEM_INIT,
                      $urandom_range(0, 15), $urandom_range(0, 255), d,
                      $urandom_range(0, 7));
    endfunction

    directed_row_t directed[$];
    sched_result_t fixed_results[$];

    // Hand-checked rows carry a typed answer; the rest rely on the predictor.
    function automatic void row(sched_req_t r, logic fx, sched_result_t e);
        directed_row_t d;
        d.req = r; d.fixed = fx; d.res = e;
        directed.push_back(d);
    endfunction

    task automatic build_directed();
        // Empty scheduler: nothing to run, nothing to wake, no caller.
        row(mk(MODE_SCHEDULE, 0, 0, 0, 0), 1, '{4'd0, 1'b0, 1'b0, 1'b0});
        row(mk(MODE_TICK, 0, 0, 0, 0), 1, '{4'd0, 1'b0, 1'b0, 1'b0});
        row(mk(MODE_PEND, 0, 0, 0, 0), 1, '{4'd0, 1'b0, 1'b0, 1'b0});
        row(mk(MODE_DELAY, 0, 0, 32'hFFFF_FFFF, 0), 1, '{4'd0, 1'b0, 1'b0, 1'b0});
        row(mk(MODE_INSTALL, 15, 255, 32'hFFFF_FFFF, 7), 0, '0);
        row(mk(MODE_INSTALL, 0, 0, 0, 0), 0, '0);
        row(mk(MODE_INSTALL, 3, 255, 0, 0), 0, '0);       // tie, later wins
        row(mk(MODE_SCHEDULE, 0, 0, 0, 0), 1, '{4'd3, 1'b1, 1'b0, 1'b0});
        row(mk(MODE_MUTEX_INIT, 0, 0, 0, 7), 0, '0);
        row(mk(MODE_PEND, 0, 0, 0, 7), 1, '{4'd3, 1'b1, 1'b0, 1'b1});
        row(mk(MODE_PEND, 0, 0, 0, 7), 0, '0);            // blocks with no timeout
        row(mk(MODE_POST, 0, 0, 0, 7), 0, '0);            // wakes the waiter
        row(mk(MODE_POST, 0, 0, 0, 7), 0, '0);
        row(mk(MODE_POST, 0, 0, 0, 7), 0, '0);            // token already set
        row(mk(MODE_DELAY, 0, 0, 2, 0), 0, '0);
        row(mk(MODE_PEND, 0, 0, 1, 5), 0, '0);            // timed wait
        row(mk(MODE_TICK, 0, 0, 0, 0), 0, '0);
        row(mk(MODE_TICK, 0, 0, 0, 0), 0, '0);
        row(mk(MODE_PEND, 0, 0, 0, 4), 0, '0);
        row(mk(MODE_SEM_INIT, 0, 0, 0, 4), 0, '0);        // waiter goes dormant
        row(mk(MODE_DELAY, 0, 0, 0, 0), 0, '0);           // zero delay: full wrap
        row(mk(MODE_SCHEDULE, 0, 0, 0, 0), 0, '0);
        row(mk(MODE_INSTALL, 15, 1, 0, 0), 0, '0);        // reinstall
        row(mk(MODE_SCHEDULE, 0, 0, 0, 0), 0, '0);
    endtask

    task automatic drive_all();
        sched_result_t pred;
        burst_left = 0;
        build_directed();
        foreach (directed[k])
        begin
            if (directed[k].fixed)
            begin
                pred = directed[k].res;
                fixed_results.push_back(pred);
            end
            send_request(directed[k].req);
            if (directed[k].fixed)
            begin
                pred = fixed_results.pop_front();
                if (expected_results[$] !== pred)
                begin
                    $error("directed row %0d: expected %h, predicted %h", k, pred,
                           expected_results[$]);
                    errors++;
                end
            end
        end
        wait_drained();
        for (int n = 0; n < N_RANDOM; n++)
        begin
            // pause once so every result drains, then fill up against a stalled sink
            if (n == 300)
            begin
                wait_drained();
                hold_off <= 1'b1;
            end
            if (n == 320) hold_off <= 1'b0;
            send_request(random_request());
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stall pattern, plus a long hold-off counted here
    // ------------------------------------------------------------------------
    int stall_len;
    int hold_cnt;

    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_off && hold_cnt < 400)
        begin
            hold_cnt <= hold_cnt + 1;
            m_tready <= 1'b0;
        end
        else if (stall_len > 0)
        begin
            stall_len <= stall_len - 1;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            stall_len <= $urandom_range(1, 8);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no request pending: %h", m_tdata);
                errors++;
            end
            else
            begin
                sched_result_t e;
                e = expected_results.pop_front();
                if (m_tdata[3:0] !== e.cur)
                begin
                    $error("active_task expected %0d actual %0d", e.cur, m_tdata[3:0]);
                    errors++;
                end
                if (m_tdata[4] !== e.vld)
                begin
                    $error("task_valid expected %0d actual %0d", e.vld, m_tdata[4]);
                    errors++;
                end
                if (m_tdata[5] !== e.woke)
                begin
                    $error("woke_any expected %0d actual %0d", e.woke, m_tdata[5]);
                    errors++;
                end
                if (m_tdata[6] !== e.acq)
                begin
                    $error("acquired expected %0d actual %0d", e.acq, m_tdata[6]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        errors      = 0;
        cycles      = 0;
        stall_len   = 0;
        hold_cnt    = 0;
        hold_off    = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        clear_shadow();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        drive_all();
        wait_drained();
        repeat (60) @(negedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
sv/pts_pkg.sv
sv/pts_datapath.sv
sv/pts_ctrl.sv
sv/priority_task_scheduler_semaphores.sv
tb/tb_top.sv
